### design/aip_pkg.sv
package aip_pkg;

	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int DIG_W    = 6;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} aip_status_t;

	// character codes
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_B_UP  = 8'h42;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_B_LO  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;
	localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

	// radix codes
	localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
	localparam logic [RADIX_W-1:0] BASE_BIN  = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

	// one classified character, front to back
	typedef struct packed {
		logic                last;
		logic                first;
		logic [RADIX_W-1:0]  radix;
		logic                ws;
		logic                plus;
		logic                minus;
		logic                zero;
		logic                is_x;
		logic                is_b;
		logic                dig_ok;
		logic [DIG_W-1:0]    dig;
	} aip_class_t;

	// parse outcome flags, back to finish
	typedef struct packed {
		logic inner_neg;
		logic outer_neg;
		logic seen;
		logic invalid;
		logic overflow;
	} aip_flags_t;

endpackage

### design/aip_if.sv
interface aip_char_if import aip_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  char_code;
	logic               last_char;
	logic [RADIX_W-1:0] radix;

	modport source(output valid, char_code, last_char, radix, input ready);
	modport sink(input valid, char_code, last_char, radix, output ready);
endinterface

interface aip_result_if import aip_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [STATUS_W-1:0]       status;

	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

### design/aip_front.sv
module aip_front import aip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	aip_char_if.sink    chars,
	output logic        push_valid,
	input  logic        push_ready,
	output aip_class_t  push_item
);

	logic              first_q;
	logic [CHAR_W-1:0] c;

	assign c = chars.char_code;
	assign chars.ready = push_ready;
	assign push_valid  = chars.valid;

	always_comb begin
		push_item        = '0;
		push_item.last   = chars.last_char;
		push_item.first  = first_q;
		push_item.radix  = chars.radix;
		push_item.ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		push_item.plus   = (c == CH_PLUS);
		push_item.minus  = (c == CH_MINUS);
		push_item.zero   = (c == CH_0);
		push_item.is_x   = (c == CH_X_LO) || (c == CH_X_UP);
		push_item.is_b   = (c == CH_B_LO) || (c == CH_B_UP);
		if (c >= CH_0 && c <= CH_9) begin
			push_item.dig_ok = 1'b1;
			push_item.dig    = DIG_W'(c - CH_0);
		end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
			push_item.dig_ok = 1'b1;
			push_item.dig    = DIG_W'(c - CH_A_LO + LETTER_OFS);
		end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
			push_item.dig_ok = 1'b1;
			push_item.dig    = DIG_W'(c - CH_A_UP + LETTER_OFS);
		end
	end

	// track the string boundary so the back end samples radix once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (chars.valid && push_ready) begin
			first_q <= chars.last_char;
		end
	end

endmodule

### design/aip_queue.sv
module aip_queue import aip_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  aip_class_t  push_item,
	output logic        pop_valid,
	input  logic        pop,
	output aip_class_t  pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	aip_class_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/aip_back.sv
module aip_back import aip_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  aip_class_t            q_item,
	output logic                  q_pop,
	input  logic                  rec_ready,
	output logic                  rec_valid,
	output logic [VALUE_BITS-1:0] rec_acc,
	output aip_flags_t            rec_flags
);

	localparam int VB = VALUE_BITS;
	localparam int MW = VALUE_BITS + 7;
	localparam logic [VB-1:0] HALF = {1'b1, {(VB - 1){1'b0}}};

	typedef enum logic [6:0] {
		PH_LEAD       = 7'b0000001,
		PH_AFTER_SIGN = 7'b0000010,
		PH_AFTER_ZERO = 7'b0000100,
		PH_AFTER_B    = 7'b0001000,
		PH_NEED_DIGIT = 7'b0010000,
		PH_DIGITS     = 7'b0100000,
		PH_TRAIL      = 7'b1000000
	} aip_phase_t;

	aip_phase_t          phase_q, phase_n;
	logic                outer_q, outer_n;
	logic                inner_q, inner_n;
	logic [VB-1:0]       acc_q, acc_n;
	logic [RADIX_W-1:0]  base_q, base_n;
	logic                seen_q, seen_n;
	logic                inv_q, inv_n;
	logic                ovf_q, ovf_n;

	logic                rec_valid_s1;
	logic [VB-1:0]       rec_acc_s1;
	aip_flags_t          rec_flags_s1;

	logic [RADIX_W-1:0]  base_cur;
	logic [RADIX_W-1:0]  mul_base;
	logic [RADIX_W-1:0]  oct_base;
	logic [MW-1:0]       mac;
	logic                mac_ovf;
	logic                dig_lt_base;
	logic                start;
	logic                take;
	logic                s1_free;
	logic                pop_last;

	assign s1_free  = !rec_valid_s1 || rec_ready;
	assign q_pop    = q_valid && (!q_item.last || s1_free);
	assign pop_last = q_pop && q_item.last;

	assign rec_valid = rec_valid_s1;
	assign rec_acc   = rec_acc_s1;
	assign rec_flags = rec_flags_s1;

	always_comb begin
		base_cur    = q_item.first ? q_item.radix : base_q;
		mul_base    = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
		oct_base    = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
		mac         = MW'(acc_q) * MW'(mul_base) + MW'(q_item.dig);
		mac_ovf     = mac > MW'(HALF);
		dig_lt_base = q_item.dig_ok && (q_item.dig < base_cur);

		phase_n = phase_q;
		outer_n = outer_q;
		inner_n = inner_q;
		acc_n   = acc_q;
		base_n  = base_cur;
		seen_n  = seen_q;
		inv_n   = inv_q;
		ovf_n   = ovf_q;
		start   = 1'b0;
		take    = 1'b0;

		if (!inv_q) begin
			case (phase_q)
				PH_LEAD: begin
					if (q_item.plus) begin
						phase_n = PH_AFTER_SIGN;
					end else if (q_item.minus) begin
						outer_n = 1'b1;
						phase_n = PH_AFTER_SIGN;
					end else if (!q_item.ws) begin
						start = 1'b1;
					end
				end
				PH_AFTER_SIGN: begin
					if (q_item.plus || q_item.minus) begin
						inv_n = 1'b1;
					end else if (!q_item.ws) begin
						start = 1'b1;
					end
				end
				PH_AFTER_ZERO: begin
					if ((base_cur == BASE_AUTO || base_cur == BASE_HEX) && q_item.is_x) begin
						base_n  = BASE_HEX;
						phase_n = PH_NEED_DIGIT;
					end else if (base_cur == BASE_AUTO && q_item.is_b) begin
						base_n  = BASE_BIN;
						seen_n  = 1'b0;
						phase_n = PH_AFTER_B;
					end else begin
						base_n = oct_base;
						if (q_item.dig_ok && q_item.dig < oct_base) begin
							take = 1'b1;
						end else if (q_item.ws) begin
							phase_n = PH_TRAIL;
						end else begin
							inv_n = 1'b1;
						end
					end
				end
				PH_AFTER_B: begin
					if (q_item.plus) begin
						phase_n = PH_NEED_DIGIT;
					end else if (q_item.minus) begin
						inner_n = 1'b1;
						phase_n = PH_NEED_DIGIT;
					end else if (dig_lt_base) begin
						take = 1'b1;
					end else begin
						inv_n = 1'b1;
					end
				end
				PH_NEED_DIGIT: begin
					if (dig_lt_base) begin
						take = 1'b1;
					end else begin
						inv_n = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (dig_lt_base) begin
						take = 1'b1;
					end else if (q_item.ws) begin
						phase_n = PH_TRAIL;
					end else begin
						inv_n = 1'b1;
					end
				end
				default: begin
					if (!q_item.ws) begin
						inv_n = 1'b1;
					end
				end
			endcase
		end

		// first character of the number itself
		if (start) begin
			if (base_cur == BASE_ONE || base_cur > BASE_MAX) begin
				inv_n = 1'b1;
			end else if (q_item.zero) begin
				seen_n  = 1'b1;
				acc_n   = '0;
				phase_n = PH_AFTER_ZERO;
			end else if (base_cur == BASE_AUTO) begin
				if (q_item.dig_ok && q_item.dig < BASE_DEC) begin
					base_n = BASE_DEC;
					take   = 1'b1;
				end else begin
					inv_n = 1'b1;
				end
			end else if (dig_lt_base) begin
				take = 1'b1;
			end else begin
				inv_n = 1'b1;
			end
		end

		// accumulate one digit; freeze the magnitude once it overflows
		if (take) begin
			seen_n  = 1'b1;
			phase_n = PH_DIGITS;
			if (!ovf_q) begin
				if (mac_ovf) begin
					ovf_n = 1'b1;
				end else begin
					acc_n = mac[VB-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			outer_q <= 1'b0;
			inner_q <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
			seen_q  <= 1'b0;
			inv_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (q_pop) begin
			if (q_item.last) begin
				phase_q <= PH_LEAD;
				outer_q <= 1'b0;
				inner_q <= 1'b0;
				acc_q   <= '0;
				base_q  <= '0;
				seen_q  <= 1'b0;
				inv_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				outer_q <= outer_n;
				inner_q <= inner_n;
				acc_q   <= acc_n;
				base_q  <= base_n;
				seen_q  <= seen_n;
				inv_q   <= inv_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
		end else begin
			rec_valid_s1 <= pop_last || (rec_valid_s1 && !rec_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (pop_last) begin
			rec_acc_s1             <= acc_n;
			rec_flags_s1.inner_neg <= inner_n;
			rec_flags_s1.outer_neg <= outer_n;
			rec_flags_s1.seen      <= seen_n;
			rec_flags_s1.invalid   <= inv_n || (phase_n == PH_AFTER_B)
				|| (phase_n == PH_NEED_DIGIT);
			rec_flags_s1.overflow  <= ovf_n;
		end
	end

endmodule

### design/aip_finish.sv
module aip_finish import aip_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	output logic                  rec_ready,
	input  logic [VALUE_BITS-1:0] rec_acc,
	input  aip_flags_t            rec_flags,
	aip_result_if.source          results
);

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	aip_status_t               status_q;
	aip_status_t               status_n;
	logic                      range_hit;
	logic [VALUE_BITS-1:0]     signed_mag;

	assign rec_ready      = !valid_q || results.ready;
	assign results.valid  = valid_q;
	assign results.value  = value_q;
	assign results.status = status_q;

	always_comb begin
		// the magnitude never passes half range, so the top bit marks it reached
		range_hit = rec_flags.overflow || (!rec_flags.inner_neg && rec_acc[VALUE_BITS-1]);
		if (!rec_flags.seen) begin
			status_n = ST_INVALID;
		end else if (range_hit) begin
			status_n = ST_RANGE;
		end else if (rec_flags.invalid) begin
			status_n = ST_INVALID;
		end else begin
			status_n = ST_OK;
		end
		signed_mag = (rec_flags.inner_neg ^ rec_flags.outer_neg) ? ('0 - rec_acc) : rec_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_ready) begin
			valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_valid) begin
			status_q <= status_n;
			value_q  <= (status_n == ST_OK) ? VALUE_W'(signed'(signed_mag)) : '0;
		end
	end

endmodule

### design/ascii_integer_parser.sv
// Channel   Dir  Transaction payload
// chars     in   char_code[7:0], last_char, radix[5:0] (radix taken on a string's first char)
// results   out  value[63:0] signed, status[1:0] (0 ok, 1 invalid, 2 out of range)
//
// Throughput: one character per cycle while the queue has room and no string end is held;
// the digit loop is a single multiply-add of the magnitude by the base in the back-end stage.
// Path: the last char passes the character queue, the parser's record register and the result register.
// Reset: arst_n clears all control state at once; there is no clearing pass.
// Stalls: a character queue decouples the classifier from the parser, and a
// stalled result only holds the parser when a string end arrives behind it.
module ascii_integer_parser import aip_pkg::*; #(
	parameter int VALUE_BITS  = 64,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	aip_char_if.sink       chars,
	aip_result_if.source   results
);

	// front end to queue
	logic                  push_valid;
	logic                  push_ready;
	aip_class_t            push_item;

	// queue to parser
	logic                  q_valid;
	logic                  q_pop;
	aip_class_t            q_item;

	// parser to result stage
	logic                  rec_valid;
	logic                  rec_ready;
	logic [VALUE_BITS-1:0] rec_acc;
	aip_flags_t            rec_flags;

	// classify each character: whitespace, sign, prefix letter, digit value
	aip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// hold classified characters so either side can stall alone
	aip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// advance the parse state and accumulate the magnitude
	aip_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rec_ready (rec_ready),
		.rec_valid (rec_valid),
		.rec_acc   (rec_acc),
		.rec_flags (rec_flags)
	);

	// resolve status, apply signs, sign-extend and register the result
	aip_finish #(
		.VALUE_BITS (VALUE_BITS)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_acc   (rec_acc),
		.rec_flags (rec_flags),
		.results   (results)
	);

endmodule
